### hw/rtl/counting_semaphore_wait_queue_unit_assert.svh
// assertion macros for the semaphore wait queue unit
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define CSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("semaphore queue check failed");

// next-cycle implication, disabled in reset
`define CSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("semaphore queue check failed");

`endif

### hw/rtl/csq_pkg.sv
// shared types, constants and the saturating count adder
package csq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_WIDTH    = 8;
  localparam int MAX_RESULTS = 17;
  localparam int MAX_RELEASE = MAX_RESULTS - 1;
  localparam int CNT_W       = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W       = $clog2(MAX_RELEASE + 1);

  localparam logic [1:0] OP_WAIT    = 2'd0;
  localparam logic [1:0] OP_SIGNAL  = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  localparam logic [1:0] KIND_WAIT    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_SIGNAL  = 2'd2;
  localparam logic [1:0] KIND_RESTORE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REL,
    S_FIN
  } csq_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    logic [CNT_W-1:0] r;
    s = {a[CNT_W-1], a} + {b[CNT_W-1], b};
    if (s[CNT_W] != s[CNT_W-1]) begin
      r = s[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
    end else begin
      r = s[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/csq_fifo.sv
// circular wait queue of thread ids with a registered head read
module csq_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  csq_pkg::fifo_ctl_t           ctl,
  input  logic [csq_pkg::ID_WIDTH-1:0] push_data,
  output logic [csq_pkg::ID_WIDTH-1:0] rd_data,
  output logic [csq_pkg::FILL_W-1:0]   fill
);
  import csq_pkg::*;

  localparam int SUM_W = IDX_W + 1;

  logic [ID_WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [IDX_W-1:0]    head;
  logic [IDX_W-1:0]    head_next;
  logic [IDX_W-1:0]    tail;
  logic [SUM_W-1:0]    tail_sum;

  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(fill);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
    head_next = head;
    if (ctl.pop) begin
      head_next = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      case ({ctl.push, ctl.pop})
        2'b10:   fill <= fill + FILL_W'(1);
        2'b01:   fill <= fill - FILL_W'(1);
        default: fill <= fill;
      endcase
    end
  end

  // read runs one address ahead so the head entry is ready every cycle
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_data;
    end
    if (ctl.push && (tail == head_next)) begin
      rd_data <= push_data;
    end else begin
      rd_data <= mem[head_next];
    end
  end

endmodule

### hw/rtl/counting_semaphore_wait_queue_unit.sv
// Counting semaphore with a 16-entry FIFO of waiting thread ids. An item is
// taken only while the block is idle and in_stall is low. Wait, restore and
// the unused op code are accepted, then executed; a signal is accepted and
// executed, takes one release step per released waiter, then finishes, since
// the queue head is read through one registered memory port and one release
// leaves per cycle while the output is not stalled. Count steps share one
// saturating adder. A stalled output delays the sequencer by the length of
// the stall. A write to initial_count is taken only while idle; while the
// queue is empty it also reloads the count. No clearing pass runs at reset.
`include "counting_semaphore_wait_queue_unit_assert.svh"

module counting_semaphore_wait_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  thread_id,
  input  logic [15:0] signal_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  released_id,
  output logic [15:0] return_value,
  output logic        overflow,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import csq_pkg::*;

  csq_state_t state, state_next;

  logic [CNT_W-1:0]    initial_count;
  logic [CNT_W-1:0]    sem_count;
  logic [1:0]          item_op;
  logic [ID_WIDTH-1:0] item_tid;
  logic [CNT_W-1:0]    item_n;
  logic [CNT_W-1:0]    addend, addend_next;
  logic [CNT_W-1:0]    ret_val, ret_val_next;
  logic [REL_W-1:0]    remaining, remaining_next;

  fifo_ctl_t           fifo_ctl;
  logic [ID_WIDTH-1:0] rd_data;
  logic [FILL_W-1:0]   fill;

  logic [CNT_W-1:0] add_in, sum;
  logic [CNT_W-1:0] lim;
  logic [REL_W-1:0] num;
  logic             n_zero, n_pos, have;
  logic             accept, out_free, count_we, sig_load, rel_step, load_out;
  logic [1:0]       kind_next;
  logic [7:0]       id_next;
  logic [15:0]      rv_next;
  logic             ovf_next, last_next;

  csq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .push_data (item_tid),
    .rd_data   (rd_data),
    .fill      (fill)
  );

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  // shared saturating adder: step of one while executing, latched addend later
  always_comb begin
    if (state == S_EXEC) begin
      add_in = (item_op == OP_WAIT) ? {CNT_W{1'b1}} : CNT_W'(1);
    end else begin
      add_in = addend;
    end
    sum = sat_add(sem_count, add_in);
  end

  // release count for a signal: min(n, fill, release limit) for positive n, one if any wait for zero, else none
  always_comb begin
    n_zero = (item_n == '0);
    n_pos  = !item_n[CNT_W-1] && !n_zero;
    have   = (fill != '0);
    lim    = item_n;
    if (CNT_W'(fill) < lim) begin
      lim = CNT_W'(fill);
    end
    if (CNT_W'(MAX_RELEASE) < lim) begin
      lim = CNT_W'(MAX_RELEASE);
    end
    if (n_zero) begin
      num          = have ? REL_W'(1) : '0;
      addend_next  = CNT_W'(1);
      ret_val_next = '0;
    end else if (n_pos && have) begin
      num          = lim[REL_W-1:0];
      addend_next  = item_n;
      ret_val_next = lim;
    end else begin
      num          = '0;
      addend_next  = '0;
      ret_val_next = item_n[CNT_W-1] ? item_n : '0;
    end
  end

  always_comb begin
    state_next     = state;
    fifo_ctl       = '0;
    count_we       = 1'b0;
    sig_load       = 1'b0;
    rel_step       = 1'b0;
    load_out       = 1'b0;
    kind_next      = KIND_WAIT;
    id_next        = '0;
    rv_next        = '0;
    ovf_next       = 1'b0;
    last_next      = 1'b0;
    remaining_next = remaining - REL_W'(1);
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_op)
          OP_WAIT: begin
            if (out_free) begin
              count_we      = 1'b1;
              load_out      = 1'b1;
              kind_next     = KIND_WAIT;
              rv_next       = sum[CNT_W-1] ? 16'd0 : 16'd1;
              ovf_next      = sum[CNT_W-1] && (fill == FILL_W'(QUEUE_DEPTH));
              fifo_ctl.push = sum[CNT_W-1] && (fill != FILL_W'(QUEUE_DEPTH));
              last_next     = 1'b1;
              state_next    = S_IDLE;
            end
          end
          OP_RESTORE: begin
            if (out_free) begin
              count_we   = 1'b1;
              load_out   = 1'b1;
              kind_next  = KIND_RESTORE;
              last_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
          OP_SIGNAL: begin
            sig_load   = 1'b1;
            state_next = (num != '0) ? S_REL : S_FIN;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_REL: begin
        if (out_free) begin
          fifo_ctl.pop = 1'b1;
          rel_step     = 1'b1;
          load_out     = 1'b1;
          kind_next    = KIND_RELEASE;
          id_next      = 8'(rd_data);
          if (remaining == REL_W'(1)) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          count_we   = 1'b1;
          load_out   = 1'b1;
          kind_next  = KIND_SIGNAL;
          rv_next    = ret_val;
          last_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= '0;
      sem_count     <= '0;
    end else if (count_we) begin
      sem_count <= sum;
    end else if (cfg_valid && cfg_ready) begin
      initial_count <= cfg_data;
      if (fill == '0) begin
        sem_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_op  <= op;
      item_tid <= thread_id[ID_WIDTH-1:0];
      item_n   <= signal_count;
    end
    if (sig_load) begin
      addend    <= addend_next;
      ret_val   <= ret_val_next;
      remaining <= num;
    end else if (rel_step) begin
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      kind         <= kind_next;
      released_id  <= id_next;
      return_value <= rv_next;
      overflow     <= ovf_next;
      last         <= last_next;
    end
  end

  `CSQ_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_W'(QUEUE_DEPTH))
  `CSQ_ASSERT_NOW(a_release_has_waiter, state == S_REL, fill != '0)
  `CSQ_ASSERT_NEXT(a_accept_busy, accept, state == S_EXEC)

endmodule

### test/csq_sem_checker.sv
// checker for the semaphore unit: follows items in, predicts the replies and compares them
module csq_sem_checker
  import csq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  thread_id,
  input  logic [15:0] signal_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  released_id,
  input  logic [15:0] return_value,
  input  logic        overflow,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          replies_seen,
  output int          releases_seen,
  output int          overflows_seen
);

  localparam int CNT_HI = 32767;
  localparam int CNT_LO = -32768;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [15:0] value;
    logic        ovf;
    logic        last;
  } sem_reply_t;

  sem_reply_t         replies_due[$];
  logic signed [15:0] sem_cnt;
  logic signed [15:0] init_cnt;
  logic [7:0]         waiter_ids[QUEUE_DEPTH];
  int                 q_head;
  int                 q_fill;

  function automatic logic signed [15:0] sat16(input int a, input int b);
    int s;
    s = a + b;
    if (s > CNT_HI) s = CNT_HI;
    else if (s < CNT_LO) s = CNT_LO;
    return s[15:0];
  endfunction

  task automatic add_reply(input logic [1:0] k, input logic [7:0] id, input int value,
                           input logic ovf, input logic fin);
    sem_reply_t r;
    r.kind  = k;
    r.id    = id;
    r.value = value[15:0];
    r.ovf   = ovf;
    r.last  = fin;
    replies_due.push_back(r);
  endtask

  task automatic release_head();
    add_reply(KIND_RELEASE, waiter_ids[q_head], 0, 1'b0, 1'b0);
    q_head = (q_head + 1) % QUEUE_DEPTH;
    q_fill--;
  endtask

  task automatic predict_sem_op(input logic [1:0] o, input logic [7:0] tid,
                                input logic signed [15:0] n);
    int num;
    int ni;
    ni = n;
    case (o)
      OP_WAIT: begin
        sem_cnt = sat16(sem_cnt, -1);
        if (sem_cnt >= 0) begin
          add_reply(KIND_WAIT, 8'd0, 1, 1'b0, 1'b1);
        end else if (q_fill < QUEUE_DEPTH) begin
          waiter_ids[(q_head + q_fill) % QUEUE_DEPTH] = tid;
          q_fill++;
          add_reply(KIND_WAIT, 8'd0, 0, 1'b0, 1'b1);
        end else begin
          // queue full: waiter dropped, count still taken
          add_reply(KIND_WAIT, 8'd0, 0, 1'b1, 1'b1);
        end
      end
      OP_SIGNAL: begin
        if (ni == 0) begin
          if (q_fill != 0) release_head();
          sem_cnt = sat16(sem_cnt, 1);
          add_reply(KIND_SIGNAL, 8'd0, 0, 1'b0, 1'b1);
        end else if (ni > 0 && q_fill != 0) begin
          num = (ni < q_fill) ? ni : q_fill;
          if (num > MAX_RELEASE) num = MAX_RELEASE;
          repeat (num) release_head();
          sem_cnt = sat16(sem_cnt, ni);
          add_reply(KIND_SIGNAL, 8'd0, num, 1'b0, 1'b1);
        end else begin
          // negative count is echoed, positive with no waiters is a no-op
          add_reply(KIND_SIGNAL, 8'd0, (ni < 0) ? ni : 0, 1'b0, 1'b1);
        end
      end
      OP_RESTORE: begin
        sem_cnt = sat16(sem_cnt, 1);
        add_reply(KIND_RESTORE, 8'd0, 0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input sem_reply_t want,
                               input sem_reply_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want kind=%0d id=%0d value=%0d ovf=%0b last=%0b | got kind=%0d id=%0d value=%0d ovf=%0b last=%0b",
               what, want.kind, want.id, $signed(want.value), want.ovf, want.last,
               got.kind, got.id, $signed(got.value), got.ovf, got.last);
  endtask

  always @(posedge clk) begin : watch
    sem_reply_t got;
    sem_reply_t want;
    if (rst) begin
      replies_due.delete();
      sem_cnt        = '0;
      init_cnt       = '0;
      q_head         = 0;
      q_fill         = 0;
      mismatches     = 0;
      replies_seen   = 0;
      releases_seen  = 0;
      overflows_seen = 0;
    end else begin
      // replies first: a reply can never belong to the item taken at the same edge
      if (out_valid && !out_stall) begin
        got.kind  = kind;
        got.id    = released_id;
        got.value = return_value;
        got.ovf   = overflow;
        got.last  = last;
        replies_seen++;
        if (kind == KIND_RELEASE) releases_seen++;
        if (overflow) overflows_seen++;
        if (replies_due.size() == 0) begin
          note_mismatch("reply with nothing outstanding", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) note_mismatch("reply mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        init_cnt = $signed(cfg_data);
        if (q_fill == 0) sem_cnt = init_cnt;
      end
      if (in_valid && !in_stall) predict_sem_op(op, thread_id, $signed(signal_count));
    end
    pending <= replies_due.size();
  end

endmodule

### test/counting_semaphore_wait_queue_unit_tb.sv
// testbench top for the semaphore unit: clock, reset, stimulus, receiver stalls and verdict
module counting_semaphore_wait_queue_unit_tb;
  import csq_pkg::*;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_WAIT;
  logic [7:0]  thread_id = '0;
  logic [15:0] signal_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  released_id;
  logic [15:0] return_value;
  logic        overflow;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int mismatches, pending, replies_seen, releases_seen, overflows_seen;
  int items_sent = 0;
  int settings_used = 0;
  int hold_reqs = 0;

  counting_semaphore_wait_queue_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .thread_id(thread_id), .signal_count(signal_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .released_id(released_id), .return_value(return_value),
    .overflow(overflow), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  csq_sem_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .thread_id(thread_id), .signal_count(signal_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .released_id(released_id), .return_value(return_value),
    .overflow(overflow), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .replies_seen(replies_seen),
    .releases_seen(releases_seen), .overflows_seen(overflows_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short pauses, now and then a long one
  function automatic int pick_pause();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, free-running stretches, and long hold-offs on request
  initial begin : receiver
    int hold_seen;
    hold_seen = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 9) < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (pick_pause()) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [1:0] o, input logic [7:0] tid,
                           input logic [15:0] n, input bit no_gap);
    int gap;
    gap = (no_gap || $urandom_range(0, 99) < 45) ? 0 : pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    thread_id    <= tid;
    signal_count <= n;
    do @(posedge clk); while (in_stall);
    if (o != 2'd3) items_sent++;
  endtask

  // wait for every reply, then for the extra idle cycles in case an ignored item is in flight
  task automatic settle_block(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_count(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_items(input int count, input bit no_gap);
    int target;
    int r;
    logic [1:0]  o;
    logic [15:0] n;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) o = OP_WAIT;
      else if (r < 85) o = OP_SIGNAL;
      else if (r < 97) o = OP_RESTORE;
      else o = 2'd3;
      n = 16'($urandom_range(0, 65535));
      if (o == OP_SIGNAL) begin
        r = $urandom_range(0, 99);
        if (r < 35) n = 16'($urandom_range(1, 4));
        else if (r < 55) n = '0;
        else if (r < 72) n = 16'($urandom_range(32768, 65535));
        else if (r < 85) n = 16'($urandom_range(5, 32767));
        else if (r < 93) n = 16'h7fff;
        else n = 16'h8000;
      end
      send_item(o, 8'($urandom_range(0, 255)), n, no_gap);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: grant, fill the queue, overflow, every signal flavour
    load_count(16'd1);
    send_item(OP_WAIT, 8'h00, 16'hffff, 1'b0);
    send_item(OP_WAIT, 8'hff, 16'h0000, 1'b0);
    for (int i = 1; i < QUEUE_DEPTH; i++)
      send_item(OP_WAIT, 8'(i * 16 + 3), 16'($urandom_range(0, 65535)), 1'b0);
    send_item(OP_WAIT, 8'h5a, 16'h1234, 1'b0);
    send_item(OP_SIGNAL, 8'h00, 16'h8000, 1'b0);
    send_item(OP_SIGNAL, 8'hff, 16'h0000, 1'b0);
    send_item(OP_SIGNAL, 8'h00, 16'd3, 1'b0);
    send_item(OP_SIGNAL, 8'h00, 16'h7fff, 1'b0);
    send_item(OP_SIGNAL, 8'h00, 16'd5, 1'b0);
    send_item(OP_RESTORE, 8'hff, 16'hffff, 1'b0);
    send_item(2'd3, 8'hff, 16'hffff, 1'b0);
    send_item(OP_SIGNAL, 8'h00, 16'hffff, 1'b0);
    settle_block(SETTLE_CYCLES);

    // random phases across a spread of starting counts, extremes included
    load_count(16'h7fff);
    random_items(25, 1'b0);
    settle_block(SETTLE_CYCLES);

    load_count(16'h8000);
    random_items(25, 1'b0);
    // receiver holds off while the sender keeps pushing, so the block backs up
    hold_reqs <= hold_reqs + 1;
    random_items(30, 1'b1);
    settle_block(SETTLE_CYCLES);

    load_count(16'hfffb);
    random_items(25, 1'b0);
    settle_block(SETTLE_CYCLES);

    load_count(16'($urandom_range(0, 65535)));
    random_items(25, 1'b0);
    settle_block(SETTLE_CYCLES);

    load_count(16'd0);
    random_items(25, 1'b0);
    settle_block(SETTLE_CYCLES);

    $display("covered %0d items under %0d count settings", items_sent, settings_used);
    $display("checked %0d replies: %0d released waiters, %0d overflow replies",
             replies_seen, releases_seen, overflows_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/csq_pkg.sv
hw/rtl/csq_fifo.sv
hw/rtl/counting_semaphore_wait_queue_unit.sv
test/csq_sem_checker.sv
test/counting_semaphore_wait_queue_unit_tb.sv
